FILE: rtl/tsad_pkg.sv
package tsad_pkg;

    localparam int SAMPLE_W   = 8;
    localparam int TICK_W     = 8;
    localparam int HOLD_W     = 16;
    localparam int DIR_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_ZERO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_TWO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_FOUR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 3'd5;

    // register reset values
    localparam logic [SAMPLE_W-1:0] THRESHOLD_ZERO_RST = 8'd229;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_TWO_RST  = 8'd236;
    localparam logic [SAMPLE_W-1:0] THRESHOLD_FOUR_RST = 8'd234;
    localparam logic [TICK_W-1:0]   NEAR_LIMIT_RST     = 8'd48;
    localparam logic [TICK_W-1:0]   WINDOW_TICKS_RST   = 8'd255;
    localparam logic [HOLD_W-1:0]   HOLD_TICKS_RST     = 16'd0;

    // direction pattern codes
    localparam logic [DIR_W-1:0] DIR_0_LAG_EQUAL  = 4'd0;   // also the timeout code
    localparam logic [DIR_W-1:0] DIR_0_FOUR_LATE  = 4'd1;
    localparam logic [DIR_W-1:0] DIR_NEAR_02      = 4'd2;
    localparam logic [DIR_W-1:0] DIR_2_FOUR_EARLY = 4'd3;
    localparam logic [DIR_W-1:0] DIR_2_LAG_EQUAL  = 4'd4;
    localparam logic [DIR_W-1:0] DIR_2_FOUR_LATE  = 4'd5;
    localparam logic [DIR_W-1:0] DIR_NEAR_24      = 4'd6;
    localparam logic [DIR_W-1:0] DIR_4_TWO_EARLY  = 4'd7;
    localparam logic [DIR_W-1:0] DIR_4_LAG_EQUAL  = 4'd8;
    localparam logic [DIR_W-1:0] DIR_4_TWO_LATE   = 4'd9;
    localparam logic [DIR_W-1:0] DIR_NEAR_04      = 4'd10;
    localparam logic [DIR_W-1:0] DIR_0_FOUR_EARLY = 4'd11;
    localparam logic [DIR_W-1:0] DIR_OVERHEAD     = 4'd12;
    localparam logic [DIR_W-1:0] DIR_TIMEOUT      = DIR_0_LAG_EQUAL;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'b001,
        PH_MEASURE = 3'b010,
        PH_HOLD    = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        SENSOR_ZERO = 2'd0,
        SENSOR_TWO  = 2'd1,
        SENSOR_FOUR = 2'd2
    } sensor_t;

endpackage

FILE: rtl/three_sensor_arrival_direction_core.sv
// Arrival-direction classifier for three transducers. One transaction of three
// samples is taken per clock while s_ready is high; a transaction is first
// held in an input register and processed from there, and its result (if any)
// is shown from an output register; a result passes the input register and
// then the output register before it is visible. The rate is one transaction
// per cycle while the output side does not stall, set by the single pass from
// input register to output register; s_ready drops only while a result waits
// on m_ready and the input register is full.
// Configuration writes take effect at once and are meant for idle periods.
module three_sensor_arrival_direction_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tsad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tsad_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tsad_pkg::SAMPLE_W-1:0]   s_sample_zero,
    input  logic [tsad_pkg::SAMPLE_W-1:0]   s_sample_two,
    input  logic [tsad_pkg::SAMPLE_W-1:0]   s_sample_four,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tsad_pkg::DIR_W-1:0]      m_direction,
    output logic                            m_timed_out,
    output logic [tsad_pkg::TICK_W-1:0]     m_gap_zero_two,
    output logic [tsad_pkg::TICK_W-1:0]     m_gap_zero_four,
    output logic [tsad_pkg::TICK_W-1:0]     m_gap_two_four
);
    import tsad_pkg::*;

    // configuration
    logic [SAMPLE_W-1:0] thr_zero_reg, thr_two_reg, thr_four_reg;
    logic [TICK_W-1:0]   near_limit_reg, window_ticks_reg;
    logic [HOLD_W-1:0]   hold_ticks_reg;

    // input register
    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_zero_reg, in_two_reg, in_four_reg;

    // measurement state
    phase_t              phase_reg, phase_next;
    sensor_t             first_reg, first_next;
    logic [TICK_W-1:0]   elapsed_reg, elapsed_next;
    logic [TICK_W-1:0]   arr_a_reg, arr_a_next;
    logic [TICK_W-1:0]   arr_b_reg, arr_b_next;
    logic [1:0]          caught_reg, caught_next;
    logic [HOLD_W-1:0]   hold_left_reg, hold_left_next;

    // output register
    logic                out_valid_reg;
    logic [DIR_W-1:0]    out_dir_reg;
    logic                out_to_reg;
    logic [TICK_W-1:0]   out_g02_reg, out_g04_reg, out_g24_reg;

    logic                proc_fire;
    logic                hit0, hit2, hit4, hit_a, hit_b;
    logic [TICK_W-1:0]   t0, t2, t4, g02, g04, g24;
    logic                res_valid, res_to;
    logic [DIR_W-1:0]    res_dir;
    logic [TICK_W-1:0]   res_g02, res_g04, res_g24;

    function automatic logic [TICK_W-1:0] abs_diff(input logic [TICK_W-1:0] x,
                                                   input logic [TICK_W-1:0] y);
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic logic [DIR_W-1:0] classify(input sensor_t first,
                                                  input logic [TICK_W-1:0] n,
                                                  input logic [TICK_W-1:0] d02,
                                                  input logic [TICK_W-1:0] d04,
                                                  input logic [TICK_W-1:0] d24);
        logic [DIR_W-1:0] code;
        if (d02 < n && d04 < n && d24 < n) begin
            code = DIR_OVERHEAD;
        end else begin
            case (first)
                SENSOR_ZERO: begin
                    if (d02 < n)        code = DIR_NEAR_02;
                    else if (d04 < n)   code = DIR_NEAR_04;
                    else if (d04 < d02) code = DIR_0_FOUR_EARLY;
                    else if (d04 > d02) code = DIR_0_FOUR_LATE;
                    else                code = DIR_0_LAG_EQUAL;
                end
                SENSOR_TWO: begin
                    if (d02 < n)        code = DIR_NEAR_02;
                    else if (d24 < n)   code = DIR_NEAR_24;
                    else if (d24 < d02) code = DIR_2_FOUR_EARLY;
                    else if (d24 > d02) code = DIR_2_FOUR_LATE;
                    else                code = DIR_2_LAG_EQUAL;
                end
                default: begin
                    if (d04 < n)        code = DIR_NEAR_04;
                    else if (d24 < n)   code = DIR_NEAR_24;
                    else if (d24 < d04) code = DIR_4_TWO_EARLY;
                    else if (d24 > d04) code = DIR_4_TWO_LATE;
                    else                code = DIR_4_LAG_EQUAL;
                end
            endcase
        end
        return code;
    endfunction

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    assign hit0 = in_zero_reg >= thr_zero_reg;
    assign hit2 = in_two_reg  >= thr_two_reg;
    assign hit4 = in_four_reg >= thr_four_reg;

    always_comb begin
        phase_next     = phase_reg;
        first_next     = first_reg;
        elapsed_next   = elapsed_reg;
        arr_a_next     = arr_a_reg;
        arr_b_next     = arr_b_reg;
        caught_next    = caught_reg;
        hold_left_next = hold_left_reg;
        hit_a          = 1'b0;
        hit_b          = 1'b0;
        t0             = '0;
        t2             = '0;
        t4             = '0;
        res_valid      = 1'b0;
        res_to         = 1'b0;
        res_dir        = DIR_TIMEOUT;
        res_g02        = '0;
        res_g04        = '0;
        res_g24        = '0;

        case (first_reg)
            SENSOR_ZERO: begin hit_a = hit2; hit_b = hit4; end
            SENSOR_TWO:  begin hit_a = hit0; hit_b = hit4; end
            default:     begin hit_a = hit0; hit_b = hit2; end
        endcase

        if (elapsed_reg != {TICK_W{1'b1}}) begin
            elapsed_next = elapsed_reg + 1'b1;
        end
        if (hit_a && !caught_reg[0]) begin
            arr_a_next     = elapsed_next;
            caught_next[0] = 1'b1;
        end
        if (hit_b && !caught_reg[1]) begin
            arr_b_next     = elapsed_next;
            caught_next[1] = 1'b1;
        end

        case (first_reg)
            SENSOR_ZERO: begin t2 = arr_a_next; t4 = arr_b_next; end
            SENSOR_TWO:  begin t0 = arr_a_next; t4 = arr_b_next; end
            default:     begin t0 = arr_a_next; t2 = arr_b_next; end
        endcase
        g02 = abs_diff(t0, t2);
        g04 = abs_diff(t0, t4);
        g24 = abs_diff(t2, t4);

        // speculative measurement values are discarded outside PH_MEASURE or without proc_fire
        if (phase_reg != PH_MEASURE || !proc_fire) begin
            elapsed_next = elapsed_reg;
            arr_a_next   = arr_a_reg;
            arr_b_next   = arr_b_reg;
            caught_next  = caught_reg;
        end

        if (proc_fire) begin
            unique case (phase_reg)
                PH_HOLD: begin
                    if (hold_left_reg != '0) begin
                        hold_left_next = hold_left_reg - 1'b1;
                    end
                    if (hold_left_reg <= HOLD_W'(1)) begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_MEASURE: begin
                    if (caught_next == 2'b11) begin
                        res_valid = 1'b1;
                        res_dir   = classify(first_reg, near_limit_reg, g02, g04, g24);
                        res_g02   = g02;
                        res_g04   = g04;
                        res_g24   = g24;
                    end else if (elapsed_next >= window_ticks_reg) begin
                        res_valid = 1'b1;
                        res_to    = 1'b1;
                    end
                    if (res_valid) begin
                        hold_left_next = hold_ticks_reg;
                        phase_next     = (hold_ticks_reg != '0) ? PH_HOLD : PH_IDLE;
                    end
                end
                default: begin
                    if (hit0 || hit2 || hit4) begin
                        if (hit0)      first_next = SENSOR_ZERO;
                        else if (hit2) first_next = SENSOR_TWO;
                        else           first_next = SENSOR_FOUR;
                        phase_next   = PH_MEASURE;
                        elapsed_next = '0;
                        arr_a_next   = '0;
                        arr_b_next   = '0;
                        caught_next  = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_zero_reg     <= THRESHOLD_ZERO_RST;
            thr_two_reg      <= THRESHOLD_TWO_RST;
            thr_four_reg     <= THRESHOLD_FOUR_RST;
            near_limit_reg   <= NEAR_LIMIT_RST;
            window_ticks_reg <= WINDOW_TICKS_RST;
            hold_ticks_reg   <= HOLD_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_THRESHOLD_ZERO: thr_zero_reg     <= cfg_wdata[SAMPLE_W-1:0];
                CFG_THRESHOLD_TWO:  thr_two_reg      <= cfg_wdata[SAMPLE_W-1:0];
                CFG_THRESHOLD_FOUR: thr_four_reg     <= cfg_wdata[SAMPLE_W-1:0];
                CFG_NEAR_LIMIT:     near_limit_reg   <= cfg_wdata[TICK_W-1:0];
                CFG_WINDOW_TICKS:   window_ticks_reg <= cfg_wdata[TICK_W-1:0];
                CFG_HOLD_TICKS:     hold_ticks_reg   <= cfg_wdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            first_reg     <= SENSOR_ZERO;
            elapsed_reg   <= '0;
            arr_a_reg     <= '0;
            arr_b_reg     <= '0;
            caught_reg    <= '0;
            hold_left_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire && res_valid) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            phase_reg     <= phase_next;
            first_reg     <= first_next;
            elapsed_reg   <= elapsed_next;
            arr_a_reg     <= arr_a_next;
            arr_b_reg     <= arr_b_next;
            caught_reg    <= caught_next;
            hold_left_reg <= hold_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_zero_reg <= s_sample_zero;
            in_two_reg  <= s_sample_two;
            in_four_reg <= s_sample_four;
        end
        if (proc_fire && res_valid) begin
            out_dir_reg <= res_dir;
            out_to_reg  <= res_to;
            out_g02_reg <= res_g02;
            out_g04_reg <= res_g04;
            out_g24_reg <= res_g24;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_direction     = out_dir_reg;
    assign m_timed_out     = out_to_reg;
    assign m_gap_zero_two  = out_g02_reg;
    assign m_gap_zero_four = out_g04_reg;
    assign m_gap_two_four  = out_g24_reg;

endmodule

FILE: rtl/tsad_checker.sv
module tsad_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [tsad_pkg::DIR_W-1:0]      m_direction,
    input logic                            m_timed_out,
    input logic [tsad_pkg::TICK_W-1:0]     m_gap_zero_two,
    input logic [tsad_pkg::TICK_W-1:0]     m_gap_zero_four,
    input logic [tsad_pkg::TICK_W-1:0]     m_gap_two_four
);
    import tsad_pkg::*;

    logic [TICK_W:0] sum_a, sum_b, sum_c;

    assign sum_a = {1'b0, m_gap_zero_four} + {1'b0, m_gap_two_four};
    assign sum_b = {1'b0, m_gap_zero_two} + {1'b0, m_gap_two_four};
    assign sum_c = {1'b0, m_gap_zero_two} + {1'b0, m_gap_zero_four};

    // no result leaves the block right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds its direction, timeout flag and zero-two gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_direction)
            && $stable(m_timed_out) && $stable(m_gap_zero_two))
        else $error("stalled result changed");

    // timeout results carry the timeout code and zero gaps
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_timed_out |-> m_direction == DIR_TIMEOUT
            && m_gap_zero_two == '0 && m_gap_zero_four == '0 && m_gap_two_four == '0)
        else $error("timeout result with nonzero fields");

    // three arrivals on one time line: the largest gap is the sum of the others
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_timed_out |-> ({1'b0, m_gap_zero_two} == sum_a
            || {1'b0, m_gap_zero_four} == sum_b || {1'b0, m_gap_two_four} == sum_c))
        else $error("inconsistent arrival gaps");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_direction <= DIR_OVERHEAD)
        else $error("direction code out of range");

endmodule

bind three_sensor_arrival_direction_core tsad_checker u_tsad_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_direction     (m_direction),
    .m_timed_out     (m_timed_out),
    .m_gap_zero_two  (m_gap_zero_two),
    .m_gap_zero_four (m_gap_zero_four),
    .m_gap_two_four  (m_gap_two_four)
);

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsad_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic [DIR_W-1:0]  direction;
        logic              timed_out;
        logic [TICK_W-1:0] gap_zero_two;
        logic [TICK_W-1:0] gap_zero_four;
        logic [TICK_W-1:0] gap_two_four;
    } arrival_result_t;

    // Tracks the classifier state and holds the direction results still owed.
    class direction_scoreboard;
        logic [SAMPLE_W-1:0] thr[3];
        logic [TICK_W-1:0]   near_lim;
        logic [TICK_W-1:0]   window;
        logic [HOLD_W-1:0]   hold_len;
        logic [HOLD_W-1:0]   hold_left;
        phase_t              phase;
        sensor_t             first;
        logic [TICK_W-1:0]   elapsed;
        logic [TICK_W-1:0]   arr_a;
        logic [TICK_W-1:0]   arr_b;
        logic [1:0]          caught;
        arrival_result_t     awaited_q[$];
        int                  errors;
        int                  results;
        int                  timeouts;
        int                  code_hits[16];

        function new();
            thr[0]    = THRESHOLD_ZERO_RST;
            thr[1]    = THRESHOLD_TWO_RST;
            thr[2]    = THRESHOLD_FOUR_RST;
            near_lim  = NEAR_LIMIT_RST;
            window    = WINDOW_TICKS_RST;
            hold_len  = HOLD_TICKS_RST;
            hold_left = '0;
            phase     = PH_IDLE;
            first     = SENSOR_ZERO;
            elapsed   = '0;
            arr_a     = '0;
            arr_b     = '0;
            caught    = '0;
            errors    = 0;
            results   = 0;
            timeouts  = 0;
            foreach (code_hits[i]) code_hits[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_THRESHOLD_ZERO: thr[0]   = val[SAMPLE_W-1:0];
                CFG_THRESHOLD_TWO:  thr[1]   = val[SAMPLE_W-1:0];
                CFG_THRESHOLD_FOUR: thr[2]   = val[SAMPLE_W-1:0];
                CFG_NEAR_LIMIT:     near_lim = val[TICK_W-1:0];
                CFG_WINDOW_TICKS:   window   = val[TICK_W-1:0];
                CFG_HOLD_TICKS:     hold_len = val[HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [TICK_W-1:0] gap_of(logic [TICK_W-1:0] a, logic [TICK_W-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        function logic [DIR_W-1:0] classify(logic [TICK_W-1:0] g02, logic [TICK_W-1:0] g04,
                                            logic [TICK_W-1:0] g24);
            if (g02 < near_lim && g04 < near_lim && g24 < near_lim) return DIR_OVERHEAD;
            case (first)
                SENSOR_ZERO: begin
                    if (g02 < near_lim) return DIR_NEAR_02;
                    if (g04 < near_lim) return DIR_NEAR_04;
                    if (g04 < g02)      return DIR_0_FOUR_EARLY;
                    if (g04 > g02)      return DIR_0_FOUR_LATE;
                    return DIR_0_LAG_EQUAL;
                end
                SENSOR_TWO: begin
                    if (g02 < near_lim) return DIR_NEAR_02;
                    if (g24 < near_lim) return DIR_NEAR_24;
                    if (g24 < g02)      return DIR_2_FOUR_EARLY;
                    if (g24 > g02)      return DIR_2_FOUR_LATE;
                    return DIR_2_LAG_EQUAL;
                end
                default: begin
                    if (g04 < near_lim) return DIR_NEAR_04;
                    if (g24 < near_lim) return DIR_NEAR_24;
                    if (g24 < g04)      return DIR_4_TWO_EARLY;
                    if (g24 > g04)      return DIR_4_TWO_LATE;
                    return DIR_4_LAG_EQUAL;
                end
            endcase
        endfunction

        function void close_event();
            if (hold_len != 0) begin
                hold_left = hold_len;
                phase     = PH_HOLD;
            end else begin
                hold_left = '0;
                phase     = PH_IDLE;
            end
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s0, logic [SAMPLE_W-1:0] s2,
                                  logic [SAMPLE_W-1:0] s4);
            logic            hit[3];
            logic            ha;
            logic            hb;
            logic [TICK_W-1:0] t0;
            logic [TICK_W-1:0] t2;
            logic [TICK_W-1:0] t4;
            arrival_result_t r;
            hit[0] = s0 >= thr[0];
            hit[1] = s2 >= thr[1];
            hit[2] = s4 >= thr[2];

            if (phase == PH_HOLD) begin
                if (hold_left != 0) hold_left--;
                if (hold_left == 0) phase = PH_IDLE;
                return;
            end

            if (phase != PH_MEASURE) begin
                phase = PH_IDLE;
                if (hit[0])      first = SENSOR_ZERO;
                else if (hit[1]) first = SENSOR_TWO;
                else if (hit[2]) first = SENSOR_FOUR;
                else return;
                phase   = PH_MEASURE;
                elapsed = '0;
                arr_a   = '0;
                arr_b   = '0;
                caught  = '0;
                return;
            end

            if (elapsed != '1) elapsed++;

            // arr_a tracks the lower-numbered of the two watched sensors
            case (first)
                SENSOR_ZERO: begin ha = hit[1]; hb = hit[2]; end
                SENSOR_TWO:  begin ha = hit[0]; hb = hit[2]; end
                default:     begin ha = hit[0]; hb = hit[1]; end
            endcase
            if (ha && !caught[0]) begin arr_a = elapsed; caught[0] = 1'b1; end
            if (hb && !caught[1]) begin arr_b = elapsed; caught[1] = 1'b1; end

            if (caught == 2'b11) begin
                case (first)
                    SENSOR_ZERO: begin t0 = '0;    t2 = arr_a; t4 = arr_b; end
                    SENSOR_TWO:  begin t0 = arr_a; t2 = '0;    t4 = arr_b; end
                    default:     begin t0 = arr_a; t2 = arr_b; t4 = '0;    end
                endcase
                r.gap_zero_two  = gap_of(t0, t2);
                r.gap_zero_four = gap_of(t0, t4);
                r.gap_two_four  = gap_of(t2, t4);
                r.direction     = classify(r.gap_zero_two, r.gap_zero_four, r.gap_two_four);
                r.timed_out     = 1'b0;
                awaited_q.push_back(r);
                close_event();
                return;
            end

            if (elapsed >= window) begin
                r           = '0;
                r.direction = DIR_TIMEOUT;
                r.timed_out = 1'b1;
                awaited_q.push_back(r);
                close_event();
            end
        endfunction

        function void check_result(arrival_result_t got);
            arrival_result_t want;
            results++;
            if (awaited_q.size() == 0) begin
                $error("unexpected result: direction %0d timed_out %0b",
                       got.direction, got.timed_out);
                errors++;
                return;
            end
            want = awaited_q.pop_front();
            if (want.timed_out) timeouts++;
            else code_hits[want.direction]++;
            if (got.direction !== want.direction) begin
                $error("direction: expected %0d, got %0d", want.direction, got.direction);
                errors++;
            end
            if (got.timed_out !== want.timed_out) begin
                $error("timed_out: expected %0d, got %0d", want.timed_out, got.timed_out);
                errors++;
            end
            if (got.gap_zero_two !== want.gap_zero_two) begin
                $error("gap_zero_two: expected %0d, got %0d",
                       want.gap_zero_two, got.gap_zero_two);
                errors++;
            end
            if (got.gap_zero_four !== want.gap_zero_four) begin
                $error("gap_zero_four: expected %0d, got %0d",
                       want.gap_zero_four, got.gap_zero_four);
                errors++;
            end
            if (got.gap_two_four !== want.gap_two_four) begin
                $error("gap_two_four: expected %0d, got %0d",
                       want.gap_two_four, got.gap_two_four);
                errors++;
            end
        endfunction

        function bit busy();
            return phase != PH_IDLE;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample_zero = '0;
    logic [SAMPLE_W-1:0]   s_sample_two  = '0;
    logic [SAMPLE_W-1:0]   s_sample_four = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [DIR_W-1:0]      m_direction;
    logic                  m_timed_out;
    logic [TICK_W-1:0]     m_gap_zero_two;
    logic [TICK_W-1:0]     m_gap_zero_four;
    logic [TICK_W-1:0]     m_gap_two_four;

    direction_scoreboard sb = new();

    int send_idle   = 0;
    int recv_idle   = 0;
    int stall_req   = 0;
    int stall_left  = 0;
    int sent_total  = 0;
    int rand_items  = 0;
    int quiet_count = 0;

    three_sensor_arrival_direction_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_zero   (s_sample_zero),
        .s_sample_two    (s_sample_two),
        .s_sample_four   (s_sample_four),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_direction     (m_direction),
        .m_timed_out     (m_timed_out),
        .m_gap_zero_two  (m_gap_zero_two),
        .m_gap_zero_four (m_gap_zero_four),
        .m_gap_two_four  (m_gap_two_four)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // result side: random back-pressure plus requested long hold-offs
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_result({m_direction, m_timed_out, m_gap_zero_two,
                                 m_gap_zero_four, m_gap_two_four});
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (stall_req > 0) begin
                stall_left = stall_req - 1;
                stall_req  = 0;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99, 0) >= recv_idle);
            end
        end
    end

    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] any_lvl();
        return SAMPLE_W'($urandom_range(255, 0));
    endfunction

    function automatic logic [SAMPLE_W-1:0] above_lvl(logic [SAMPLE_W-1:0] thr);
        return SAMPLE_W'($urandom_range(255, thr));
    endfunction

    function automatic logic [SAMPLE_W-1:0] below_lvl(logic [SAMPLE_W-1:0] thr);
        return (thr == 0) ? 8'd0 : SAMPLE_W'($urandom_range(thr - 1, 0));
    endfunction

    task automatic send_item(logic [SAMPLE_W-1:0] a, logic [SAMPLE_W-1:0] b,
                             logic [SAMPLE_W-1:0] c);
        while ($urandom_range(99, 0) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample_zero <= a;
        s_sample_two  <= b;
        s_sample_four <= c;
        do @(posedge aclk); while (!s_ready);
        sb.note_sample(a, b, c);
        sent_total++;
    endtask

    // stop offering, wait for every owed result and let the pipeline empty
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        @(posedge aclk);
        sb.set_reg(idx, val[CFG_DATA_W-1:0]);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(int t0, int t2, int t4, int near_val, int win, int hold);
        write_reg(CFG_THRESHOLD_ZERO, t0);
        write_reg(CFG_THRESHOLD_TWO, t2);
        write_reg(CFG_THRESHOLD_FOUR, t4);
        write_reg(CFG_NEAR_LIMIT, near_val);
        write_reg(CFG_WINDOW_TICKS, win);
        write_reg(CFG_HOLD_TICKS, hold);
    endtask

    // feed quiet ticks (or anything, while held) until the classifier is idle
    task automatic settle();
        while (sb.busy()) begin
            if (sb.phase == PH_HOLD)
                send_item(any_lvl(), any_lvl(), any_lvl());
            else
                send_item(below_lvl(sb.thr[0]), below_lvl(sb.thr[1]), below_lvl(sb.thr[2]));
            quiet_count++;
        end
    endtask

    // one arrival: trigger at tick 0, the lower watched sensor arrives at ta,
    // the higher one at tb; ticks 0..n_ticks are sent
    task automatic run_event(sensor_t trig, int ta, int tb, int n_ticks);
        int                  arr[3];
        int                  lo;
        int                  hi;
        logic [SAMPLE_W-1:0] v[3];
        case (trig)
            SENSOR_ZERO: begin lo = 1; hi = 2; end
            SENSOR_TWO:  begin lo = 0; hi = 2; end
            default:     begin lo = 0; hi = 1; end
        endcase
        arr[int'(trig)] = 0;
        arr[lo] = ta;
        arr[hi] = tb;
        for (int k = 0; k <= n_ticks; k++) begin
            for (int s = 0; s < 3; s++) begin
                if (s == int'(trig))
                    v[s] = (k == 0) ? above_lvl(sb.thr[s]) : any_lvl();
                else if (k > 0 && k >= arr[s])
                    v[s] = above_lvl(sb.thr[s]);
                else
                    v[s] = below_lvl(sb.thr[s]);
            end
            send_item(v[0], v[1], v[2]);
        end
    endtask

    task automatic random_event();
        int      win;
        int      span;
        int      ta;
        int      tb;
        int      n_ticks;
        int      pick;
        int      start;
        sensor_t trig;
        settle();
        start = sent_total;
        pick  = $urandom_range(99, 0);
        if (pick < 15) begin
            repeat ($urandom_range(6, 1))
                send_item(any_lvl(), any_lvl(), any_lvl());
        end else begin
            win     = (sb.window == 0) ? 1 : int'(sb.window);
            span    = (win > 30) ? 30 : win;
            trig    = sensor_t'($urandom_range(2, 0));
            ta      = $urandom_range(span + 2, 1);
            tb      = ($urandom_range(4, 0) == 0) ? ta : $urandom_range(span + 2, 1);
            n_ticks = (ta > tb) ? ta : tb;
            if (n_ticks > win) n_ticks = win;
            // cut some sequences short, only where the window stays short
            if (pick < 30 && win <= 30) n_ticks = $urandom_range(n_ticks, 0);
            run_event(trig, ta, tb, n_ticks);
        end
        rand_items += sent_total - start;
    endtask

    task automatic apply_setting(int k);
        case (k)
            0: configure($urandom_range(220, 40), $urandom_range(220, 40),
                         $urandom_range(220, 40), $urandom_range(12, 0),
                         $urandom_range(25, 2), $urandom_range(3, 0));
            1: configure(255, 255, 255, 255, 255, 0);
            2: configure(0, $urandom_range(254, 1), $urandom_range(254, 1),
                         $urandom_range(12, 0), $urandom_range(25, 2),
                         $urandom_range(4, 1));
            default: configure($urandom_range(254, 1), $urandom_range(254, 1),
                               $urandom_range(254, 1), 0, 1, $urandom_range(3, 0));
        endcase
    endtask

    initial begin
        int target;
        int codes;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, no idling
        run_event(SENSOR_ZERO, 1, 2, 2);        // reset settings: overhead
        drain();
        configure(100, 100, 100, 2, 0, 0);
        send_item(8'd0, 8'd0, 8'd0);
        run_event(SENSOR_ZERO, 1, 1, 1);        // both caught on the same tick
        run_event(SENSOR_TWO, 5, 5, 1);         // zero window times out after one tick
        drain();
        configure(100, 100, 100, 1, 4, 2);
        run_event(SENSOR_FOUR, 3, 1, 3);
        send_item(8'd255, 8'd255, 8'd255);      // ignored while held
        send_item(8'd255, 8'd255, 8'd255);
        send_item(8'd255, 8'd255, 8'd255);      // triggers on sensor zero
        send_item(8'd255, 8'd255, 8'd255);
        settle();
        run_event(SENSOR_ZERO, 2, 2, 2);        // equal lags
        settle();
        run_event(SENSOR_TWO, 9, 9, 4);         // never caught: timeout
        drain();

        for (int r = 0; r < 3; r++) begin
            case (r)
                0:       begin send_idle = 24; recv_idle = 74; end
                1:       begin send_idle = 74; recv_idle = 24; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase
            for (int k = 0; k < 4; k++) begin
                drain();
                apply_setting(k);
                target = rand_items + 48;
                while (rand_items < target) random_event();
            end
        end

        // hold off the result side so the block backs up into the input
        drain();
        configure(128, 128, 128, 4, 8, 0);
        settle();
        stall_req = 300;
        repeat (20) run_event(SENSOR_TWO, 1, 1, 1);
        drain();

        // long hold; a write during the hold must not shorten it
        configure(128, 128, 128, 4, 8, 40);
        settle();
        run_event(SENSOR_FOUR, 2, 3, 3);
        drain();
        write_reg(CFG_HOLD_TICKS, 1);
        settle();
        run_event(SENSOR_ZERO, 1, 2, 2);
        drain();

        codes = 0;
        foreach (sb.code_hits[i]) if (sb.code_hits[i] != 0) codes++;
        $display("Run: %0d input transactions (%0d random, %0d filler), %0d results, %0d timeouts.",
                 sent_total, rand_items, quiet_count, sb.results, sb.timeouts);
        $display("Direction codes returned: %0d of 13, over threshold/window/hold extremes.",
                 codes);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
